// ===== hdl/svd_pkg.sv =====
// shared types and constants for the signed varint stream decoder
`timescale 1ns / 1ps

package svd_pkg;

	localparam int unsigned MagW   = 31;
	localparam int unsigned ValueW = 32;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned LastIdx = 4;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TRUNC    = 3'd1,
		ST_TOOLONG  = 3'd2,
		ST_OVERLONG = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// decoder state carried between bytes
	typedef struct packed {
		logic [MagW-1:0] acc;
		logic            sign;
		logic [IdxW-1:0] idx;
	} dec_state_t;

	// one finished code
	typedef struct packed {
		logic              emit;
		logic [ValueW-1:0] value;
		logic [2:0]        used;
		status_t           status;
	} dec_result_t;

endpackage

// ===== hdl/svd_if.sv =====
// valid/ready channel interfaces for byte input and decoded output
`timescale 1ns / 1ps

interface svd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_end;

	modport source (output valid, output data_byte, output buffer_end, input ready);
	modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface svd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] decoded_value;
	logic [2:0]         bytes_used;
	logic [2:0]         status;

	modport source (output valid, output decoded_value, output bytes_used, output status,
		input ready);
	modport sink (input valid, input decoded_value, input bytes_used, input status,
		output ready);
endinterface

// ===== hdl/svd_decode.sv =====
// combinational step: one byte against the current state gives next state and result
`timescale 1ns / 1ps

module svd_decode (
	input  logic               [7:0] data_byte,
	input  logic                     buffer_end,
	input  svd_pkg::dec_state_t      cur,
	output svd_pkg::dec_state_t      nxt,
	output svd_pkg::dec_result_t     res
);
	import svd_pkg::*;

	logic            cont;
	logic [IdxW-1:0] idx_c;
	logic [MagW-1:0] shifted;
	dec_state_t      upd;
	status_t         st;
	logic            emit;

	assign cont = data_byte[7];

	// an index past the fifth byte behaves as the fifth byte
	always_comb begin
		if (cur.idx > IdxW'(LastIdx)) begin
			idx_c = IdxW'(LastIdx);
		end else begin
			idx_c = cur.idx;
		end
	end

	// position of the seven payload bits for middle bytes
	always_comb begin
		case (idx_c)
			3'd1:    shifted = {18'b0, data_byte[6:0], 6'b0};
			3'd2:    shifted = {11'b0, data_byte[6:0], 13'b0};
			3'd3:    shifted = {4'b0, data_byte[6:0], 20'b0};
			default: shifted = '0;
		endcase
	end

	// accumulate and classify
	always_comb begin
		upd  = cur;
		emit = 1'b0;
		st   = ST_OK;
		if (idx_c == '0) begin
			upd.acc  = {25'b0, data_byte[5:0]};
			upd.sign = data_byte[6];
			if (!cont) begin
				emit = 1'b1;
			end else if (buffer_end) begin
				emit = 1'b1;
				st   = ST_TRUNC;
			end else begin
				upd.idx = IdxW'(1);
			end
		end else if (idx_c < IdxW'(LastIdx)) begin
			upd.acc = cur.acc | shifted;
			if (cont) begin
				if (buffer_end) begin
					emit = 1'b1;
					st   = ST_TRUNC;
				end else begin
					upd.idx = idx_c + IdxW'(1);
				end
			end else begin
				emit = 1'b1;
				if (data_byte == 8'h00) begin
					st = ST_OVERLONG;
				end
			end
		end else begin
			// fifth byte carries only four bits
			emit = 1'b1;
			if (cont) begin
				st = ST_TOOLONG;
			end else if (data_byte == 8'h00) begin
				st = ST_OVERLONG;
			end else if (data_byte[6:4] != 3'b000) begin
				st = ST_OVERFLOW;
			end else begin
				upd.acc = cur.acc | {data_byte[3:0], 27'b0};
			end
		end
	end

	// result fields, state clears after every result
	always_comb begin
		res.emit   = emit;
		res.used   = idx_c + IdxW'(1);
		res.status = st;
		if (st != ST_OK) begin
			res.value = '0;
		end else if (upd.sign) begin
			res.value = ~{1'b0, upd.acc};
		end else begin
			res.value = {1'b0, upd.acc};
		end
		if (emit) begin
			nxt = '0;
		end else begin
			nxt = upd;
		end
	end

endmodule

// ===== hdl/svd_out_reg.sv =====
// output register holding one result until the downstream side takes it
`timescale 1ns / 1ps

module svd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  svd_pkg::dec_result_t res,
	output logic                 free,
	svd_out_if.source            out_ch
);
	import svd_pkg::*;

	logic              valid_q;
	logic [ValueW-1:0] value_q;
	logic [2:0]        used_q;
	status_t           status_q;

	assign free = !valid_q || out_ch.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			value_q  <= res.value;
			used_q   <= res.used;
			status_q <= res.status;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.decoded_value = value_q;
	assign out_ch.bytes_used    = used_q;
	assign out_ch.status        = status_q;

endmodule

// ===== hdl/signed_varint_stream_decoder.sv =====
// top level of the sign-prefixed varint stream decoder
// a byte transaction passes through the input register and then the result register
// throughput: one byte per cycle while no result is stalled, set by the accumulator update loop
// a result stalled downstream holds the input register only if that byte also ends a code
// reset: arst_n clears the input and output valid flags and the decoder state at once
`timescale 1ns / 1ps

module signed_varint_stream_decoder (
	input logic        clk,
	input logic        arst_n,
	svd_in_if.sink     in_ch,
	svd_out_if.source  out_ch
);
	import svd_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        end_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        out_free;
	logic        adv_s1;
	logic        load_out;

	// stage 1 moves on unless its result has nowhere to go
	assign adv_s1      = valid_s1 && (!res.emit || out_free);
	assign load_out    = valid_s1 && res.emit && out_free;
	assign in_ch.ready = !valid_s1 || adv_s1;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			end_s1  <= in_ch.buffer_end;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	svd_decode u_decode (
		.data_byte  (data_s1),
		.buffer_end (end_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res)
	);

	svd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load_out),
		.res    (res),
		.free   (out_free),
		.out_ch (out_ch)
	);

endmodule

// ===== hdl/svd_checker.sv =====
// port-level assertions for the decoder and their bind to the top level
`timescale 1ns / 1ps

module svd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] decoded_value,
	input logic [2:0]  bytes_used,
	input logic [2:0]  status
);
	import svd_pkg::*;

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(decoded_value)
			&& $stable(bytes_used) && $stable(status))
		else $error("result changed while stalled");

	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> decoded_value == 32'd0)
		else $error("nonzero value on error result");

	// a code spans one to five bytes
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bytes_used >= 3'd1 && bytes_used <= 3'd5)
		else $error("byte count out of range");

	// only the fifth byte can be too long or overflow, overlong needs a second byte
	a_used_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status != ST_TOOLONG && status != ST_OVERFLOW) || bytes_used == 3'd5)
			&& (status != ST_OVERLONG || bytes_used >= 3'd2))
		else $error("status does not match byte count");

endmodule

bind signed_varint_stream_decoder svd_checker u_svd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.decoded_value (out_ch.decoded_value),
	.bytes_used    (out_ch.bytes_used),
	.status        (out_ch.status)
);

// ===== tb/tb_signed_varint_stream_decoder.sv =====
// self-checking testbench for the signed varint stream decoder
`timescale 1ns / 1ps

module tb_signed_varint_stream_decoder;
	import svd_pkg::*;

	// one decoded code as seen on the output channel
	typedef struct packed {
		logic signed [ValueW-1:0] value;
		logic [2:0]               used;
		status_t                  status;
	} code_result_t;

	// directed stimulus row, with the result typed in where it is obvious
	typedef struct packed {
		logic [7:0]   data;
		logic         last;
		logic         known;
		code_result_t result;
	} stim_row_t;

	localparam int DirRows = 26;
	localparam stim_row_t DIRECTED [DirRows] = '{
		// single-byte codes: zero, minus one, largest and smallest one-byte values
		'{8'h00, 1'b0, 1'b1, '{32'h0000_0000, 3'd1, ST_OK}},
		'{8'h40, 1'b0, 1'b1, '{32'hFFFF_FFFF, 3'd1, ST_OK}},
		'{8'h3F, 1'b0, 1'b1, '{32'h0000_003F, 3'd1, ST_OK}},
		'{8'h7F, 1'b0, 1'b1, '{32'hFFFF_FFC0, 3'd1, ST_OK}},
		// truncated on the first byte
		'{8'h80, 1'b1, 1'b1, '{32'h0000_0000, 3'd1, ST_TRUNC}},
		// full five-byte negative extreme, buffer end on the final byte is ignored
		'{8'hFF, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'hFF, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'hFF, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'hFF, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h0F, 1'b1, 1'b1, '{32'h8000_0000, 3'd5, ST_OK}},
		// fifth byte still continues
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h80, 1'b1, 1'b1, '{32'h0000_0000, 3'd5, ST_TOOLONG}},
		// trailing zero byte
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h00, 1'b0, 1'b1, '{32'h0000_0000, 3'd2, ST_OVERLONG}},
		// fifth byte with high bits set
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h80, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h7F, 1'b1, 1'b1, '{32'h0000_0000, 3'd5, ST_OVERFLOW}},
		// truncated on a middle byte
		'{8'h81, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h85, 1'b1, 1'b1, '{32'h0000_0000, 3'd2, ST_TRUNC}},
		// two-byte negative code, left to the predictor
		'{8'hC5, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}},
		'{8'h01, 1'b0, 1'b0, '{32'h0, 3'd0, ST_OK}}
	};

	logic clk;
	logic arst_n;

	svd_in_if  in_ch ();
	svd_out_if out_ch ();

	signed_varint_stream_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// decoder state mirrored by the predictor
	logic [MagW-1:0] mag_acc;
	logic            mag_sign;
	logic [IdxW-1:0] byte_pos;

	code_result_t pending_codes[$];
	int           fail_count;
	int           bytes_sent;
	int           send_idle_pct;
	int           recv_idle_pct;
	bit           recv_hold_req;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

	// decode one byte, update the mirrored state and report a finished code
	task automatic varint_decode_byte(input logic [7:0] b, input logic last,
		output logic emits, output code_result_t res);
		logic [IdxW-1:0] pos;
		logic            cont;
		status_t         st;
		pos   = (byte_pos > LastIdx) ? IdxW'(LastIdx) : byte_pos;
		cont  = b[7];
		emits = 1'b1;
		st    = ST_OK;
		if (pos == 0) begin
			mag_acc  = MagW'(b[5:0]);
			mag_sign = b[6];
			if (cont && !last) begin
				emits    = 1'b0;
				byte_pos = IdxW'(1);
			end else if (cont) begin
				st = ST_TRUNC;
			end
		end else if (pos < LastIdx) begin
			mag_acc = mag_acc | (MagW'(b[6:0]) << (6 + 7 * (pos - 1)));
			if (cont && !last) begin
				emits    = 1'b0;
				byte_pos = pos + IdxW'(1);
			end else if (cont) begin
				st = ST_TRUNC;
			end else if (b == 8'h00) begin
				st = ST_OVERLONG;
			end
		end else begin
			if (cont)
				st = ST_TOOLONG;
			else if (b == 8'h00)
				st = ST_OVERLONG;
			else if ((b & 8'h70) != 8'h00)
				st = ST_OVERFLOW;
			else
				mag_acc = mag_acc | (MagW'(b[3:0]) << 27);
		end
		res = '0;
		if (emits) begin
			res.used   = 3'(pos + 1);
			res.status = st;
			if (st == ST_OK)
				res.value = mag_sign ? ~{1'b0, mag_acc} : {1'b0, mag_acc};
			mag_acc  = '0;
			mag_sign = 1'b0;
			byte_pos = '0;
		end
	endtask

	// offer one byte, with random gaps, and predict once it is taken
	task automatic send_byte(input logic [7:0] b, input logic last, input logic known,
		input code_result_t typed);
		logic         emits;
		code_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.data_byte  <= b;
		in_ch.buffer_end <= last;
		do @(posedge clk); while (!in_ch.ready);
		varint_decode_byte(b, last, emits, res);
		if (emits)
			pending_codes.push_back(known ? typed : res);
		bytes_sent++;
	endtask

	// one random code: mostly well formed, some too long, some noise
	task automatic send_random_code();
		int         kind;
		int         len;
		logic [7:0] b;
		logic       last;
		kind = $urandom_range(99);
		if (kind < 10) begin
			send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
		end else if (kind < 16) begin
			for (int i = 0; i <= LastIdx; i++)
				send_byte(8'($urandom_range(255)) | 8'h80, 1'($urandom_range(1)), 1'b0, '0);
		end else begin
			len = $urandom_range(1, LastIdx + 1);
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom_range(255));
				if (i < len - 1) begin
					b[7] = 1'b1;
					last = ($urandom_range(99) < 4);
				end else begin
					b[7] = 1'b0;
					last = 1'($urandom_range(1));
					// a valid fifth byte only carries the low nibble
					if (i == LastIdx && $urandom_range(99) < 80)
						b = 8'($urandom_range(1, 15));
				end
				send_byte(b, last, 1'b0, '0);
				if (last && i < len - 1)
					break;
			end
		end
	endtask

	// hold off until every expected code has arrived
	task automatic drain_pending();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_codes.size() != 0);
	endtask

	// result sink: random stalls plus one long counted hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (recv_hold_req) begin
				hold_left     = 64;
				recv_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare each output transaction with the oldest expected code
	always @(posedge clk) begin
		code_result_t exp_code;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_codes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: value=%0d used=%0d status=%0d",
						out_ch.decoded_value, out_ch.bytes_used, out_ch.status);
			end else begin
				exp_code = pending_codes.pop_front();
				if (out_ch.decoded_value !== exp_code.value
					|| out_ch.bytes_used !== exp_code.used
					|| out_ch.status !== exp_code.status) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: expected value=%0d used=%0d status=%s",
							exp_code.value, exp_code.used, exp_code.status.name());
						$display("          got value=%0d used=%0d status=%0d",
							out_ch.decoded_value, out_ch.bytes_used, out_ch.status);
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		in_ch.valid      = 1'b0;
		in_ch.data_byte  = 8'h00;
		in_ch.buffer_end = 1'b0;
		out_ch.ready     = 1'b0;
		arst_n           = 1'b0;
		mag_acc          = '0;
		mag_sign         = 1'b0;
		byte_pos         = '0;
		fail_count       = 0;
		bytes_sent       = 0;
		recv_hold_req    = 1'b0;
		send_idle_pct    = 17;
		recv_idle_pct    = 48;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DirRows; r++)
			send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].known,
				DIRECTED[r].result);

		// random, sender idles less than receiver
		while (bytes_sent < 260)
			send_random_code();
		drain_pending();

		// random, receiver idles less than sender
		send_idle_pct = 48;
		recv_idle_pct = 17;
		while (bytes_sent < 490)
			send_random_code();
		drain_pending();

		// random with no idling, starting under a long output stall
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_req = 1'b1;
		while (bytes_sent < 720)
			send_random_code();

		drain_pending();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_codes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== signed_varint_stream_decoder.f =====
hdl/svd_pkg.sv
hdl/svd_if.sv
hdl/svd_decode.sv
hdl/svd_out_reg.sv
hdl/signed_varint_stream_decoder.sv
hdl/svd_checker.sv
tb/tb_signed_varint_stream_decoder.sv
